@@ rtl/dfe_pkg.sv @@
// ----------------------------------------------------------------------------
// dfe_pkg
// Shared constants and sideband types for the dipole field evaluator.
// ----------------------------------------------------------------------------
package dfe_pkg;

    localparam int POS_W      = 32;
    localparam int FRAC_BITS  = 16;
    localparam int SQRT_STEPS = 32;   // one root bit per stage
    localparam int DIV_STEPS  = 31;   // one quotient bit per stage
    localparam int DIV_LANES  = 4;    // three unit vector lanes and the reciprocal

    // round(2^32 / (4 pi))
    localparam logic [28:0] INV_FOUR_PI_Q32 = 29'd341782638;

    typedef enum logic [1:0] {
        REG_MOMENT_X = 2'd0,
        REG_MOMENT_Y = 2'd1,
        REG_MOMENT_Z = 2'd2
    } cfg_reg_t;

    // control that rides along with an item through the long units
    typedef struct packed {
        logic       origin;
        logic [4:0] shift;
        logic [2:0] neg;
    } div_sb_t;

    typedef struct packed {
        div_sb_t         ctl;
        logic [2:0][31:0] mag;
    } isq_sb_t;

endpackage

@@ rtl/dfe_isqrt.sv @@
// ----------------------------------------------------------------------------
// dfe_isqrt
// Pipelined integer square root, floor(sqrt(rad)), one root bit per stage.
// ----------------------------------------------------------------------------
module dfe_isqrt (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [63:0]       in_rad,
    input  dfe_pkg::isq_sb_t  in_sb,
    output logic              out_valid,
    output logic [31:0]       out_root,
    output dfe_pkg::isq_sb_t  out_sb
);

    localparam int N = dfe_pkg::SQRT_STEPS;

    logic [33:0]      rem_reg  [N];
    logic [31:0]      root_reg [N];
    logic [63:0]      rad_reg  [N];
    dfe_pkg::isq_sb_t sb_reg   [N];
    logic [N-1:0]     v_reg;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [33:0]      rem_in;
        logic [31:0]      root_in;
        logic [63:0]      rad_in;
        dfe_pkg::isq_sb_t sb_in;
        logic             v_in;
        logic [35:0]      cur;
        logic [35:0]      trial;
        logic             ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign sb_in   = in_sb;
            assign v_in    = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign sb_in   = sb_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        assign cur   = {rem_in, rad_in[63:62]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = (cur >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? 34'(cur - trial) : cur[33:0];
                root_reg[k] <= {root_in[30:0], ge};
                rad_reg[k]  <= {rad_in[61:0], 2'b00};
                sb_reg[k]   <= sb_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_sb    = sb_reg[N-1];

endmodule

@@ rtl/dfe_div.sv @@
// ----------------------------------------------------------------------------
// dfe_div
// Pipelined restoring divider, several lanes over one shared divisor,
// one quotient bit per stage. Partial remainder must start below divisor.
// ----------------------------------------------------------------------------
module dfe_div (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        en,
    input  logic                                        in_valid,
    input  logic [dfe_pkg::DIV_LANES-1:0][31:0]         in_rem,
    input  logic [dfe_pkg::DIV_LANES-1:0][30:0]         in_low,
    input  logic [31:0]                                 in_den,
    input  dfe_pkg::div_sb_t                            in_sb,
    output logic                                        out_valid,
    output logic [dfe_pkg::DIV_LANES-1:0][30:0]         out_quo,
    output dfe_pkg::div_sb_t                            out_sb
);

    localparam int N = dfe_pkg::DIV_STEPS;
    localparam int L = dfe_pkg::DIV_LANES;

    logic [L-1:0][31:0] rem_reg [N];
    logic [L-1:0][30:0] low_reg [N];
    logic [L-1:0][30:0] quo_reg [N];
    logic [31:0]        den_reg [N];
    dfe_pkg::div_sb_t   sb_reg  [N];
    logic [N-1:0]       v_reg;

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [L-1:0][31:0] rem_in;
        logic [L-1:0][30:0] low_in;
        logic [L-1:0][30:0] quo_in;
        logic [31:0]        den_in;
        dfe_pkg::div_sb_t   sb_in;
        logic               v_in;
        logic [L-1:0][31:0] rem_next;
        logic [L-1:0][30:0] quo_next;

        if (k == 0) begin : g_first
            assign rem_in = in_rem;
            assign low_in = in_low;
            assign quo_in = '0;
            assign den_in = in_den;
            assign sb_in  = in_sb;
            assign v_in   = in_valid;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign sb_in  = sb_reg[k-1];
            assign v_in   = v_reg[k-1];
        end

        always_comb begin
            for (int i = 0; i < L; i++) begin
                logic [32:0] cur;
                logic        ge;
                cur = {rem_in[i], low_in[i][30]};
                ge  = (cur >= {1'b0, den_in});
                rem_next[i] = ge ? 32'(cur - {1'b0, den_in}) : cur[31:0];
                quo_next[i] = {quo_in[i][29:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (en) begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                for (int i = 0; i < L; i++) begin
                    low_reg[k][i] <= {low_in[i][29:0], 1'b0};
                end
                den_reg[k] <= den_in;
                sb_reg[k]  <= sb_in;
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_quo   = quo_reg[N-1];
    assign out_sb    = sb_reg[N-1];

endmodule

@@ rtl/dipole_field_eval.sv @@
// ----------------------------------------------------------------------------
// dipole_field_eval
// Magnetic dipole field at a point, B = (3(m.u)u - m) / (4 pi |r|^3),
// signed Q16.16 in and out, saturating, fully pipelined.
// ----------------------------------------------------------------------------
//
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  cfg      | cfg_wr_en, cfg_addr, cfg_wdata         | in, write only
//  s (pos)  | s_valid/s_ready, s_pos_x/y/z           | in
//  m (fld)  | m_valid/m_ready, m_field_x/y/z,        | out
//           | m_at_origin, m_saturated               |
//
//  One transaction per cycle while the skid register is empty; the path from
//  input acceptance to m_valid runs through the 32-stage square root and the
//  31-stage divider (one bit per stage each) plus 14 arithmetic stages.
//  Reset (aresetn low, synchronous) clears the moment and all valid bits.
//  A skid register behind the output register lets one more transaction
//  enter while a result waits; when the skid holds data the whole pipeline
//  freezes, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
module dipole_field_eval (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    // positions
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    // field results
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_field_x,
    output logic signed [31:0] m_field_y,
    output logic signed [31:0] m_field_z,
    output logic               m_at_origin,
    output logic               m_saturated
);

    localparam int          E_BASE = 3 * dfe_pkg::FRAC_BITS - 121;
    localparam logic [31:0] FLD_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] FLD_MIN = 32'h8000_0000;

    // ------------------------------------------------------------------
    // moment registers
    // ------------------------------------------------------------------
    logic signed [31:0] m_reg [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) m_reg[i] <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dfe_pkg::REG_MOMENT_X: m_reg[0] <= cfg_wdata;
                dfe_pkg::REG_MOMENT_Y: m_reg[1] <= cfg_wdata;
                dfe_pkg::REG_MOMENT_Z: m_reg[2] <= cfg_wdata;
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // global advance: the pipeline moves unless the skid stage is full
    // ------------------------------------------------------------------
    logic pipe_en;
    logic skid_v_reg;
    logic out_v_reg;

    assign pipe_en = !skid_v_reg;
    assign s_ready = pipe_en;

    // ------------------------------------------------------------------
    // front end: capture, magnitude, normalize shift, squares, sum
    // ------------------------------------------------------------------
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic signed [31:0] pos_reg [3];

    logic [31:0] abs_next [3];
    logic [31:0] abs2_reg [3];
    logic [2:0]  neg2_reg, neg3_reg, neg4_reg, neg5_reg, neg6_reg;
    logic [31:0] am1_next, am1_reg;
    logic        org_next, org2_reg, org3_reg, org4_reg, org5_reg, org6_reg;

    logic [4:0]  s_next;
    logic [4:0]  s3_reg, s4_reg, s5_reg, s6_reg;
    logic [31:0] abs3_reg [3];
    logic [31:0] mag4_reg [3];
    logic [31:0] mag5_reg [3];
    logic [31:0] mag6_reg [3];
    logic [63:0] sq5_reg [3];
    logic [63:0] sn6_reg;

    always_comb begin
        logic [31:0] a01;
        logic [31:0] amax;
        for (int i = 0; i < 3; i++) begin
            abs_next[i] = pos_reg[i][31] ? (~pos_reg[i] + 32'd1) : pos_reg[i];
        end
        a01      = (abs_next[0] > abs_next[1]) ? abs_next[0] : abs_next[1];
        amax     = (a01 > abs_next[2]) ? a01 : abs_next[2];
        am1_next = amax - 32'd1;
        org_next = (amax == '0);
    end

    // least s with A*2^s > 2^30 is 30 minus the top set bit of A-1
    always_comb begin
        s_next = 5'd31;
        for (int i = 0; i < 31; i++) begin
            if (am1_reg[i]) s_next = 5'(30 - i);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= s_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pos_reg[0] <= s_pos_x;
            pos_reg[1] <= s_pos_y;
            pos_reg[2] <= s_pos_z;
            for (int i = 0; i < 3; i++) begin
                abs2_reg[i] <= abs_next[i];
                neg2_reg[i] <= pos_reg[i][31];
                abs3_reg[i] <= abs2_reg[i];
                mag4_reg[i] <= abs3_reg[i] << s3_reg;
                sq5_reg[i]  <= mag4_reg[i] * mag4_reg[i];
                mag5_reg[i] <= mag4_reg[i];
                mag6_reg[i] <= mag5_reg[i];
            end
            am1_reg  <= am1_next;
            org2_reg <= org_next;
            s3_reg   <= s_next;
            neg3_reg <= neg2_reg;
            org3_reg <= org2_reg;
            s4_reg   <= s3_reg;
            neg4_reg <= neg3_reg;
            org4_reg <= org3_reg;
            s5_reg   <= s4_reg;
            neg5_reg <= neg4_reg;
            org5_reg <= org4_reg;
            sn6_reg  <= sq5_reg[0] + sq5_reg[1] + sq5_reg[2];
            s6_reg   <= s5_reg;
            neg6_reg <= neg5_reg;
            org6_reg <= org5_reg;
        end
    end

    // ------------------------------------------------------------------
    // |r| of the normalized vector
    // ------------------------------------------------------------------
    dfe_pkg::isq_sb_t isq_sb_in, isq_sb_out;
    logic             isq_v_out;
    logic [31:0]      ln;

    always_comb begin
        isq_sb_in.ctl.origin = org6_reg;
        isq_sb_in.ctl.shift  = s6_reg;
        isq_sb_in.ctl.neg    = neg6_reg;
        for (int i = 0; i < 3; i++) isq_sb_in.mag[i] = mag6_reg[i];
    end

    dfe_isqrt u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (v6_reg),
        .in_rad    (sn6_reg),
        .in_sb     (isq_sb_in),
        .out_valid (isq_v_out),
        .out_root  (ln),
        .out_sb    (isq_sb_out)
    );

    // ------------------------------------------------------------------
    // unit vector |Xn_i| * 2^30 / Ln and reciprocal 2^61 / Ln
    // ------------------------------------------------------------------
    logic [dfe_pkg::DIV_LANES-1:0][31:0] div_rem;
    logic [dfe_pkg::DIV_LANES-1:0][30:0] div_low;
    logic [dfe_pkg::DIV_LANES-1:0][30:0] quo;
    dfe_pkg::div_sb_t                    div_sb;
    logic                                div_v_out;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            div_rem[i] = {1'b0, isq_sb_out.mag[i][31:1]};
            div_low[i] = {isq_sb_out.mag[i][0], 30'd0};
        end
        div_rem[3] = 32'h4000_0000;
        div_low[3] = '0;
    end

    dfe_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (isq_v_out),
        .in_rem    (div_rem),
        .in_low    (div_low),
        .in_den    (ln),
        .in_sb     (isq_sb_out.ctl),
        .out_valid (div_v_out),
        .out_quo   (quo),
        .out_sb    (div_sb)
    );

    // ------------------------------------------------------------------
    // back end: dot product, 1/|r|^3 / (4 pi), products, scale and clip
    // ------------------------------------------------------------------
    logic               v7_reg, v8_reg, v9_reg, v10_reg, v11_reg, v12_reg, v13_reg;
    logic [4:0]         s7_reg, s8_reg, s9_reg, s10_reg, s11_reg;
    logic               org7_reg, org8_reg, org9_reg, org10_reg, org11_reg;
    logic               org12_reg, org13_reg;

    logic signed [31:0] u_next  [3];
    logic signed [31:0] u7_reg  [3];
    logic signed [31:0] u8_reg  [3];
    logic signed [63:0] mu7_reg [3];
    logic [30:0]        inv7_reg, inv8_reg;
    logic [61:0]        isq7_reg;

    logic signed [63:0] dsum;
    logic signed [33:0] dot8_reg;
    logic [30:0]        inv2_8_reg;

    logic signed [63:0] du9_reg [3];
    logic [61:0]        i3p9_reg;

    logic signed [33:0] v_next  [3];
    logic signed [35:0] w10_reg [3];
    logic signed [35:0] w11_reg [3];
    logic [30:0]        inv3_10_reg;

    logic [59:0]        gp;
    logic [27:0]        g11_reg;

    logic signed [63:0] p12_reg [3];
    logic signed [7:0]  e_next, e12_reg;

    logic [5:0]         sh12;
    logic signed [64:0] t13_reg [3];
    logic               eneg13_reg, ebig13_reg, far13_reg;
    logic [5:0]         sh13_reg;
    logic [4:0]         lsh13_reg, rsh13_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u_next[i] = div_sb.neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
        end
    end

    assign dsum = mu7_reg[0] + mu7_reg[1] + mu7_reg[2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            v_next[i] = 34'(du9_reg[i] >>> 30);
        end
    end

    assign gp     = inv3_10_reg * dfe_pkg::INV_FOUR_PI_Q32;
    assign e_next = 8'(E_BASE) + $signed({1'b0, 7'({2'b00, s11_reg} * 7'd3)});
    assign sh12   = 6'(-e12_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
            v13_reg <= 1'b0;
        end else if (pipe_en) begin
            v7_reg  <= div_v_out;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
            v11_reg <= v10_reg;
            v12_reg <= v11_reg;
            v13_reg <= v12_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            // stage 7
            for (int i = 0; i < 3; i++) begin
                u7_reg[i]  <= u_next[i];
                mu7_reg[i] <= m_reg[i] * u_next[i];
            end
            inv7_reg <= quo[3];
            isq7_reg <= quo[3] * quo[3];
            s7_reg   <= div_sb.shift;
            org7_reg <= div_sb.origin;
            // stage 8
            for (int i = 0; i < 3; i++) u8_reg[i] <= u7_reg[i];
            dot8_reg   <= 34'(dsum >>> 30);
            inv2_8_reg <= isq7_reg[61:31];
            inv8_reg   <= inv7_reg;
            s8_reg     <= s7_reg;
            org8_reg   <= org7_reg;
            // stage 9
            for (int i = 0; i < 3; i++) du9_reg[i] <= dot8_reg * u8_reg[i];
            i3p9_reg <= inv2_8_reg * inv8_reg;
            s9_reg   <= s8_reg;
            org9_reg <= org8_reg;
            // stage 10: w = 3v - m
            for (int i = 0; i < 3; i++) begin
                w10_reg[i] <= (36'(v_next[i]) <<< 1) + 36'(v_next[i]) - 36'(m_reg[i]);
            end
            inv3_10_reg <= i3p9_reg[61:31];
            s10_reg     <= s9_reg;
            org10_reg   <= org9_reg;
            // stage 11: g = inv^3 / (4 pi)
            for (int i = 0; i < 3; i++) w11_reg[i] <= w10_reg[i];
            g11_reg   <= gp[59:32];
            s11_reg   <= s10_reg;
            org11_reg <= org10_reg;
            // stage 12
            for (int i = 0; i < 3; i++) p12_reg[i] <= w11_reg[i] * $signed({1'b0, g11_reg});
            e12_reg   <= e_next;
            org12_reg <= org11_reg;
            // stage 13: round-half-up bias for right shifts
            for (int i = 0; i < 3; i++) begin
                if (e12_reg < 0 && sh12 < 6'd63 && e12_reg > -8'sd63) begin
                    t13_reg[i] <= 65'(p12_reg[i]) + (65'sd1 <<< (sh12 - 6'd1));
                end else begin
                    t13_reg[i] <= 65'(p12_reg[i]);
                end
            end
            eneg13_reg <= (e12_reg < 0);
            ebig13_reg <= (e12_reg >= 8'sd32);
            far13_reg  <= (e12_reg <= -8'sd63);
            sh13_reg   <= sh12;
            lsh13_reg  <= e12_reg[4:0];
            rsh13_reg  <= 5'(5'd31 - e12_reg[4:0]);
            org13_reg  <= org12_reg;
        end
    end

    // stage 14: final shift and clip
    logic [31:0] fld_next [3];
    logic        sat_next;

    always_comb begin
        sat_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            logic signed [64:0] r;
            logic signed [64:0] hi;
            logic               clip;
            logic [31:0]        val;
            r  = t13_reg[i] >>> sh13_reg;
            hi = t13_reg[i] >>> rsh13_reg;
            if (eneg13_reg) begin
                if (far13_reg) begin
                    clip = 1'b0;
                    val  = '0;
                end else begin
                    clip = !(r[64:31] == '0 || r[64:31] == '1);
                    val  = clip ? (r[64] ? FLD_MIN : FLD_MAX) : r[31:0];
                end
            end else if (ebig13_reg) begin
                clip = (t13_reg[i] != '0);
                val  = clip ? (t13_reg[i][64] ? FLD_MIN : FLD_MAX) : 32'd0;
            end else begin
                clip = !(hi == '0 || hi == '1);
                val  = clip ? (t13_reg[i][64] ? FLD_MIN : FLD_MAX)
                            : (t13_reg[i][31:0] << lsh13_reg);
            end
            fld_next[i] = org13_reg ? 32'd0 : val;
            sat_next    = sat_next | (clip & !org13_reg);
        end
    end

    // ------------------------------------------------------------------
    // output register and skid
    // ------------------------------------------------------------------
    logic [31:0] out_fld_reg  [3];
    logic        out_org_reg, out_sat_reg;
    logic [31:0] skid_fld_reg [3];
    logic        skid_org_reg, skid_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end else begin
            if (pipe_en) out_v_reg <= v13_reg;
            if (skid_v_reg) begin
                if (m_ready) skid_v_reg <= 1'b0;
            end else if (out_v_reg && !m_ready) begin
                skid_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int i = 0; i < 3; i++) begin
                out_fld_reg[i]  <= fld_next[i];
                skid_fld_reg[i] <= out_fld_reg[i];
            end
            out_org_reg  <= org13_reg;
            out_sat_reg  <= sat_next;
            skid_org_reg <= out_org_reg;
            skid_sat_reg <= out_sat_reg;
        end
    end

    assign m_valid     = out_v_reg | skid_v_reg;
    assign m_field_x   = skid_v_reg ? skid_fld_reg[0] : out_fld_reg[0];
    assign m_field_y   = skid_v_reg ? skid_fld_reg[1] : out_fld_reg[1];
    assign m_field_z   = skid_v_reg ? skid_fld_reg[2] : out_fld_reg[2];
    assign m_at_origin = skid_v_reg ? skid_org_reg : out_org_reg;
    assign m_saturated = skid_v_reg ? skid_sat_reg : out_sat_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_origin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_at_origin |-> m_field_x == 0 && m_field_y == 0 &&
                                   m_field_z == 0 && !m_saturated)
        else $error("origin transaction with nonzero field");

    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_v_reg) |-> $past(out_v_reg && !m_ready))
        else $error("skid filled without a stalled output");

    a_skid_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_v_reg |=> $stable(out_v_reg) && $stable(out_fld_reg[0]))
        else $error("pipeline moved while skid was full");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams positions through dipole_field_eval under several dipole moments,
// with random gaps on the position side and random stalls on the field side.
// Every field transaction is checked against a fixed point model of the field.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] REG_UNUSED  = 2'd3;   // decodes to nothing
    localparam int         DRAIN_WAIT  = 120;    // longer than the pipeline latency
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         RAND_PER_PHASE = 110;

    typedef struct {
        logic signed [31:0] x, y, z;
    } pos_t;

    typedef struct {
        logic signed [31:0] fx, fy, fz;
        logic               origin;
        logic               sat;
    } field_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [1:0]         cfg_addr = '0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_field_x, m_field_y, m_field_z;
    logic               m_at_origin, m_saturated;

    dipole_field_eval dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pos_x(s_pos_x), .s_pos_y(s_pos_y), .s_pos_z(s_pos_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_field_x(m_field_x), .m_field_y(m_field_y), .m_field_z(m_field_z),
        .m_at_origin(m_at_origin), .m_saturated(m_saturated)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // testbench copy of the moment registers
    longint moment [3];

    pos_t   pending_pos[$];     // positions not yet offered to the block
    field_t expected_fields[$]; // predicted results, oldest first
    int     fail_count = 0;
    bit     no_idle = 1'b0;     // phase without gaps or stalls
    int     cycles = 0;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 45);
    endfunction

    // scale by 2^e with round half up, then clip to 32 bits
    function automatic longint scale_field(longint p, int e, inout bit sat);
        longint r;
        int     sh;
        if (e >= 0) begin
            if (p == 0) return 0;
            if (e >= 32) begin
                sat = 1'b1;
                return p > 0 ? 64'sd2147483647 : -64'sd2147483648;
            end
            if (p > (64'sd2147483647 >>> e)) begin
                sat = 1'b1;
                return 64'sd2147483647;
            end
            if (p < -longint'(64'd2147483648 >> e)) begin
                sat = 1'b1;
                return -64'sd2147483648;
            end
            return p <<< e;
        end
        sh = -e;
        if (sh >= 63) return 0;
        r = (p + (64'sd1 <<< (sh - 1))) >>> sh;
        if (r > 64'sd2147483647) begin
            sat = 1'b1;
            return 64'sd2147483647;
        end
        if (r < -64'sd2147483648) begin
            sat = 1'b1;
            return -64'sd2147483648;
        end
        return r;
    endfunction

    // field of the dipole at one position
    function automatic field_t dipole_field(pos_t pos);
        field_t            res;
        longint            p[3], xn[3], u[3], fld[3];
        longint unsigned   amax, sn, ln, n, root, bitv, inv, inv2, inv3, g, q;
        longint            d, dot, v, w;
        int                s, e;
        bit                sat;
        p[0] = pos.x; p[1] = pos.y; p[2] = pos.z;
        amax = 0;
        for (int i = 0; i < 3; i++) begin
            q = (p[i] < 0) ? longint'(-p[i]) : longint'(p[i]);
            if (q > amax) amax = q;
        end
        res.origin = 1'b0;
        res.sat = 1'b0;
        if (amax == 0) begin
            res.fx = '0; res.fy = '0; res.fz = '0;
            res.origin = 1'b1;
            return res;
        end
        // normalize so the largest component sits just above 2^30
        s = 0;
        while (amax <= (64'd1 << 30) && s < 31) begin
            amax = amax << 1;
            s++;
        end
        sn = 0;
        for (int i = 0; i < 3; i++) begin
            xn[i] = p[i] <<< s;
            q = (xn[i] < 0) ? longint'(-xn[i]) : longint'(xn[i]);
            sn += q * q;
        end
        // bitwise integer square root
        n = sn; root = 0; bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        ln = root;
        d = 0;
        for (int i = 0; i < 3; i++) begin
            u[i] = (xn[i] <<< 30) / longint'(ln);   // truncates toward zero
            d += moment[i] * u[i];
        end
        dot = d >>> 30;
        inv  = (64'd1 << 61) / ln;
        inv2 = (inv * inv) >> 31;
        inv3 = (inv2 * inv) >> 31;
        g    = (inv3 * 64'(dfe_pkg::INV_FOUR_PI_Q32)) >> 32;
        e = 3 * dfe_pkg::FRAC_BITS + 3 * s - 121;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            v = (dot * u[i]) >>> 30;
            w = 3 * v - moment[i];
            fld[i] = scale_field(w * longint'(g), e, sat);
        end
        res.fx = fld[0][31:0];
        res.fy = fld[1][31:0];
        res.fz = fld[2][31:0];
        res.sat = sat;
        return res;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        int r;
        logic signed [31:0] c;
        r = $urandom_range(0, 99);
        c = $urandom;
        if (r < 15) return '0;
        if (r < 20) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        if (r < 60) return c;
        return c >>> $urandom_range(1, 31);    // small magnitudes, deep shifts
    endfunction

    function automatic pos_t rand_pos();
        pos_t pos;
        if ($urandom_range(0, 99) == 0) begin
            pos.x = '0; pos.y = '0; pos.z = '0;
        end else begin
            pos.x = rand_coord(); pos.y = rand_coord(); pos.z = rand_coord();
        end
        return pos;
    endfunction

    // ------------------------------------------------------------------
    // Position driver: offers queued positions with random gaps and
    // records the expected field for each accepted transaction.
    // ------------------------------------------------------------------
    int gap_left = 0;

    always @(posedge aclk) begin
        pos_t   nxt;
        logic   took;
        pos_t   cur;
        took = s_valid && s_ready;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (took) begin
                cur.x = s_pos_x; cur.y = s_pos_y; cur.z = s_pos_z;
                expected_fields.push_back(dipole_field(cur));
            end
            if (!s_valid || took) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_pos.size() > 0) begin
                    nxt = pending_pos.pop_front();
                    s_pos_x <= nxt.x;
                    s_pos_y <= nxt.y;
                    s_pos_z <= nxt.z;
                    s_valid <= 1'b1;
                    gap_left = pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Field monitor: random back pressure, compares each transaction
    // against the oldest expected field.
    // ------------------------------------------------------------------
    int stall_left = 0;

    always @(posedge aclk) begin
        field_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_fields.size() == 0) begin
                $error("field transaction with nothing expected");
                fail_count++;
            end else begin
                want = expected_fields.pop_front();
                if (m_field_x !== want.fx) begin
                    $error("field_x expected %0d got %0d", want.fx, m_field_x);
                    fail_count++;
                end
                if (m_field_y !== want.fy) begin
                    $error("field_y expected %0d got %0d", want.fy, m_field_y);
                    fail_count++;
                end
                if (m_field_z !== want.fz) begin
                    $error("field_z expected %0d got %0d", want.fz, m_field_z);
                    fail_count++;
                end
                if (m_at_origin !== want.origin) begin
                    $error("at_origin expected %0b got %0b", want.origin, m_at_origin);
                    fail_count++;
                end
                if (m_saturated !== want.sat) begin
                    $error("saturated expected %0b got %0b", want.sat, m_saturated);
                    fail_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx != REG_UNUSED) moment[idx] = longint'(signed'(val));
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_moment(logic [31:0] mx, logic [31:0] my, logic [31:0] mz);
        write_reg(dfe_pkg::REG_MOMENT_X, mx);
        write_reg(dfe_pkg::REG_MOMENT_Y, my);
        write_reg(dfe_pkg::REG_MOMENT_Z, mz);
    endtask

    task automatic add_pos(logic signed [31:0] x, logic signed [31:0] y,
                           logic signed [31:0] z);
        pos_t pos;
        pos.x = x; pos.y = y; pos.z = z;
        pending_pos.push_back(pos);
    endtask

    // wait for every queued position to produce its field, then let
    // the pipeline settle before touching the moment again
    task automatic drain();
        wait (pending_pos.size() == 0 && !s_valid && expected_fields.size() == 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic add_directed();
        add_pos(0, 0, 0);
        add_pos(32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_pos(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
        add_pos(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        add_pos(32'sh80000000, 0, 0);
        add_pos(0, 32'sh7fffffff, 0);
        add_pos(1, 0, 0);
        add_pos(0, -1, 0);
        add_pos(0, 0, 1);
        add_pos(1, 1, 1);
        add_pos(-1, -1, -1);
        add_pos(32'sh00010000, 0, 0);
        add_pos(0, 32'sh00010000, 0);
        add_pos(0, 0, -32'sh00010000);
        add_pos(32'sh40000000, 0, 0);
        add_pos(32'sh40000001, -32'sh40000000, 5);
        add_pos(32'sh00008000, 32'sh00008000, 0);
        add_pos(-32'sh00100000, 32'sh00030000, 32'sh00001234);
        add_pos(3, -7, 2);
    endtask

    task automatic add_random(int count);
        repeat (count) pending_pos.push_back(rand_pos());
    endtask

    initial begin
        moment[0] = 0; moment[1] = 0; moment[2] = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // zero moment: every field is zero, also at the origin
        add_directed();
        drain();

        set_moment(32'h00010000, 32'h00000000, 32'hfffe0000);
        add_directed();
        add_random(40);
        drain();

        set_moment(32'h7fffffff, 32'h80000000, 32'h7fffffff);
        add_directed();
        add_random(RAND_PER_PHASE);
        drain();

        set_moment(32'h80000000, 32'h80000000, 32'h80000000);
        no_idle = 1'b1;
        add_random(RAND_PER_PHASE);
        drain();
        no_idle = 1'b0;

        // unused index must leave the moment alone
        set_moment(32'h00000001, 32'hffffffff, 32'h00000000);
        write_reg(REG_UNUSED, $urandom);
        add_random(RAND_PER_PHASE);
        drain();

        repeat (3) begin
            set_moment($urandom >> $urandom_range(0, 31), $urandom,
                       $urandom >> $urandom_range(0, 31));
            add_random(RAND_PER_PHASE);
            drain();
        end

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
